// File: rtl/elbs_pkg.sv
// shared types and constants for the exponential lower bound search unit
// no dependencies

package elbs_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int VAL_W       = 32;
    localparam int CMD_W       = 2;
    localparam int POS_W       = 15;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_CHK,
        ST_EXP_CMP,
        ST_BIN_CHK,
        ST_BIN_CMP,
        ST_FIN_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic exp_read;
        logic bound_double;
        logic load_range;
        logic bin_read;
        logic bin_update;
        logic fin_read;
        logic set_miss;
        logic set_final;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bound_lt_count;
        logic data_lt_key;
        logic lo_lt_hi;
        logic lo_lt_count;
        logic out_busy;
    } ctrl_sts_t;

endpackage

// File: rtl/elbs_ram.sv
// generic single port ram with registered read
// no dependencies

module elbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/elbs_datapath.sv
// store, element count, search bounds and result registers
// depends on elbs_pkg and elbs_ram

module elbs_datapath #(
    parameter int STORE_DEPTH = elbs_pkg::STORE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  elbs_pkg::ctrl_cmd_t               cmd,
    output elbs_pkg::ctrl_sts_t               sts,
    input  logic signed [elbs_pkg::VAL_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [elbs_pkg::POS_W-1:0]        m_position,
    output logic                              m_not_found
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int PW = elbs_pkg::POS_W;
    localparam int VW = elbs_pkg::VAL_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    logic [CW-1:0]        count_reg, count_next;
    logic signed [VW-1:0] key_reg;
    logic [CW:0]          bound_reg;
    logic [CW-1:0]        lo_reg, hi_reg;
    logic [CW-1:0]        res_pos_reg;
    logic                 res_nf_reg;
    logic [PW-1:0]        out_pos_reg;
    logic                 out_nf_reg;
    logic                 out_valid_reg, out_valid_next;

    logic [CW:0]          mid_sum;
    logic [CW-1:0]        mid;
    logic [AW-1:0]        ram_addr;
    logic                 ram_we;
    logic [VW-1:0]        ram_rdata;
    logic                 data_lt_key;
    logic [CW+PW-1:0]     pos_ext;

    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[CW:1];
    assign data_lt_key = $signed(ram_rdata) < key_reg;
    assign ram_we      = cmd.append && (count_reg < DEPTH_C);
    assign pos_ext     = {{PW{1'b0}}, res_pos_reg};

    always_comb begin
        if (cmd.exp_read) begin
            ram_addr = bound_reg[AW-1:0];
        end else if (cmd.bin_read) begin
            ram_addr = mid[AW-1:0];
        end else if (cmd.fin_read) begin
            ram_addr = lo_reg[AW-1:0];
        end else begin
            ram_addr = count_reg[AW-1:0];
        end
    end

    elbs_ram #(
        .WIDTH (VW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_value),
        .rdata (ram_rdata)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (ram_we) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg   <= s_value;
            bound_reg <= (CW+1)'(1);
        end else if (cmd.bound_double) begin
            bound_reg <= {bound_reg[CW-1:0], 1'b0};
        end
        if (cmd.load_range) begin
            lo_reg <= bound_reg[CW:1];
            hi_reg <= (bound_reg > {1'b0, count_reg}) ? count_reg : bound_reg[CW-1:0];
        end else if (cmd.bin_update) begin
            if (data_lt_key) begin
                lo_reg <= mid + CW'(1);
            end else begin
                hi_reg <= mid;
            end
        end
        if (cmd.set_miss) begin
            res_pos_reg <= count_reg;
            res_nf_reg  <= 1'b1;
        end else if (cmd.set_final) begin
            res_pos_reg <= data_lt_key ? count_reg : lo_reg;
            res_nf_reg  <= data_lt_key;
        end
        if (cmd.out_load) begin
            out_pos_reg <= pos_ext[PW-1:0];
            out_nf_reg  <= res_nf_reg;
        end
    end

    assign sts.bound_lt_count = bound_reg < {1'b0, count_reg};
    assign sts.data_lt_key    = data_lt_key;
    assign sts.lo_lt_hi       = lo_reg < hi_reg;
    assign sts.lo_lt_count    = lo_reg < count_reg;
    assign sts.out_busy       = out_valid_reg && !m_ready;

    assign m_valid     = out_valid_reg;
    assign m_position  = out_pos_reg;
    assign m_not_found = out_nf_reg;

endmodule

// File: rtl/elbs_controller.sv
// search sequencer: command decode, exponential and binary phases
// depends on elbs_pkg

module elbs_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [elbs_pkg::CMD_W-1:0]    s_command,
    input  elbs_pkg::ctrl_sts_t           sts,
    output elbs_pkg::ctrl_cmd_t           cmd
);

    elbs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= elbs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            elbs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (elbs_pkg::cmd_code_t'(s_command))
                        elbs_pkg::CMD_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        elbs_pkg::CMD_APPEND: begin
                            cmd.append = 1'b1;
                        end
                        elbs_pkg::CMD_QUERY: begin
                            cmd.start  = 1'b1;
                            state_next = elbs_pkg::ST_EXP_CHK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            elbs_pkg::ST_EXP_CHK: begin
                if (sts.bound_lt_count) begin
                    cmd.exp_read = 1'b1;
                    state_next   = elbs_pkg::ST_EXP_CMP;
                end else begin
                    cmd.load_range = 1'b1;
                    state_next     = elbs_pkg::ST_BIN_CHK;
                end
            end
            elbs_pkg::ST_EXP_CMP: begin
                if (sts.data_lt_key) begin
                    cmd.bound_double = 1'b1;
                    state_next       = elbs_pkg::ST_EXP_CHK;
                end else begin
                    cmd.load_range = 1'b1;
                    state_next     = elbs_pkg::ST_BIN_CHK;
                end
            end
            elbs_pkg::ST_BIN_CHK: begin
                if (sts.lo_lt_hi) begin
                    cmd.bin_read = 1'b1;
                    state_next   = elbs_pkg::ST_BIN_CMP;
                end else if (sts.lo_lt_count) begin
                    cmd.fin_read = 1'b1;
                    state_next   = elbs_pkg::ST_FIN_CMP;
                end else begin
                    cmd.set_miss = 1'b1;
                    state_next   = elbs_pkg::ST_DONE;
                end
            end
            elbs_pkg::ST_BIN_CMP: begin
                cmd.bin_update = 1'b1;
                state_next     = elbs_pkg::ST_BIN_CHK;
            end
            elbs_pkg::ST_FIN_CMP: begin
                cmd.set_final = 1'b1;
                state_next    = elbs_pkg::ST_DONE;
            end
            elbs_pkg::ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = elbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = elbs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/exponential_lower_bound_search_unit.sv
// Lower bound search over a store of signed 32-bit values appended in ascending
// order. A clear or an append gives no result. A query runs an exponential
// bound search and then a binary search, each probe using the single store port
// (address, then registered read data); a query holds the input until its
// result is loaded into the output register, which waits for that register
// to drain; the result then sits there while the next item is taken.
// depends on elbs_pkg, elbs_controller, elbs_datapath

module exponential_lower_bound_search_unit #(
    parameter int STORE_DEPTH = elbs_pkg::STORE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [elbs_pkg::CMD_W-1:0]        s_command,
    input  logic signed [elbs_pkg::VAL_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [elbs_pkg::POS_W-1:0]        m_position,
    output logic                              m_not_found
);

    elbs_pkg::ctrl_cmd_t cmd;
    elbs_pkg::ctrl_sts_t sts;

    elbs_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .sts       (sts),
        .cmd       (cmd)
    );

    elbs_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_position  (m_position),
        .m_not_found (m_not_found)
    );

endmodule

// File: rtl/elbs_checker.sv
// port level checks for the exponential lower bound search unit, with bind
// depends on elbs_pkg and exponential_lower_bound_search_unit

module elbs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [elbs_pkg::CMD_W-1:0]        s_command,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [elbs_pkg::POS_W-1:0]        m_position,
    input logic                              m_not_found
);

    logic s_xfer;
    logic query_xfer;

    assign s_xfer     = s_valid && s_ready;
    assign query_xfer = s_xfer && (s_command == elbs_pkg::CMD_QUERY);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_not_found))
        else $error("result changed while stalled");

    // a query occupies the block: the input is not ready in the cycle after its transfer
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        query_xfer |=> !s_ready)
        else $error("input ready right after query transfer");

    // clear, append and unused commands leave the input ready in the next cycle
    a_simple_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_command != elbs_pkg::CMD_QUERY) |=> s_ready)
        else $error("input not ready after non-query transfer");

    // a new result only appears while a query is in progress
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a query in progress");

endmodule

bind exponential_lower_bound_search_unit elbs_checker u_elbs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_command   (s_command),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_position  (m_position),
    .m_not_found (m_not_found)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench for exponential_lower_bound_search_unit: a lower-bound predictor in a scoreboard
// class checks every answer; plain tasks drive the transfers. depends on elbs_pkg and the rtl

module tb;

    localparam logic [elbs_pkg::CMD_W-1:0]        CMD_UNUSED  = 2'd3;
    localparam logic signed [elbs_pkg::VAL_W-1:0] VAL_MIN     = 32'sh8000_0000;
    localparam logic signed [elbs_pkg::VAL_W-1:0] VAL_MAX     = 32'sh7fff_ffff;
    localparam longint                            VAL_MAX_L   = 64'sd2147483647;
    localparam longint                            VAL_MIN_L   = -64'sd2147483648;
    localparam int                                ITEM_TARGET = 1550;
    localparam int                                TAIL_LOAD   = 300;
    localparam int                                HOLD_CYCLES = 400;
    localparam int                                DRAIN_WAIT  = 100;
    localparam int                                CYCLE_LIMIT = 1500000;

    localparam int RX_OPEN     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    typedef struct packed {
        logic [elbs_pkg::POS_W-1:0] position;
        logic                       not_found;
    } answer_t;

    class lower_bound_board;
        logic signed [elbs_pkg::VAL_W-1:0] store_vals [elbs_pkg::STORE_DEPTH];
        int unsigned                       entry_count;
        answer_t                           pending_answers [$];
        int                                errors;
        int                                queries;
        int                                misses;
        int                                appends_dropped;
        int                                answers_checked;
        int unsigned                       peak_count;

        function new();
            foreach (store_vals[i]) store_vals[i] = '0;
            entry_count     = 0;
            errors          = 0;
            queries         = 0;
            misses          = 0;
            appends_dropped = 0;
            answers_checked = 0;
            peak_count      = 0;
        endfunction

        function answer_t find_lower_bound(logic signed [elbs_pkg::VAL_W-1:0] key);
            int unsigned bound;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            int unsigned pos;
            bit          miss;
            answer_t     ans;
            bound = 1;
            while (bound < entry_count && store_vals[bound] < key) bound = bound * 2;
            lo = bound / 2;
            hi = (bound > entry_count) ? entry_count : bound;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (store_vals[mid] < key) lo = mid + 1;
                else hi = mid;
            end
            miss = (lo >= entry_count) || (store_vals[lo] < key);
            pos = miss ? entry_count : lo;
            ans.position  = pos[elbs_pkg::POS_W-1:0];
            ans.not_found = miss;
            if (miss) misses++;
            return ans;
        endfunction

        function void note_item(logic [elbs_pkg::CMD_W-1:0] cmd,
                                logic signed [elbs_pkg::VAL_W-1:0] val);
            case (cmd)
                elbs_pkg::CMD_CLEAR: entry_count = 0;
                elbs_pkg::CMD_APPEND: begin
                    if (entry_count < elbs_pkg::STORE_DEPTH) begin
                        store_vals[entry_count] = val;
                        entry_count++;
                        if (entry_count > peak_count) peak_count = entry_count;
                    end else begin
                        appends_dropped++;
                    end
                end
                elbs_pkg::CMD_QUERY: begin
                    pending_answers.push_back(find_lower_bound(val));
                    queries++;
                end
                default: ;
            endcase
        endfunction

        function void check_answer(logic [elbs_pkg::POS_W-1:0] position, logic not_found);
            answer_t want;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: position %0d not_found %0b", position, not_found);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            answers_checked++;
            if (position !== want.position) begin
                $error("position mismatch: expected %0d, actual %0d", want.position, position);
                errors++;
            end
            if (not_found !== want.not_found) begin
                $error("not_found mismatch: expected %0b, actual %0b", want.not_found, not_found);
                errors++;
            end
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [elbs_pkg::CMD_W-1:0]        s_command;
    logic signed [elbs_pkg::VAL_W-1:0] s_value;
    logic                              m_valid;
    logic                              m_ready;
    logic [elbs_pkg::POS_W-1:0]        m_position;
    logic                              m_not_found;

    lower_bound_board sb;
    int items_sent  = 0;
    int burst_left  = 0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int rx_mode     = RX_OPEN;
    int rx_left     = 0;
    int rx_tick     = 0;
    int cycle_count = 0;

    exponential_lower_bound_search_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_position  (m_position),
        .m_not_found (m_not_found)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // transfer monitor: results are checked before the new input is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_answer(m_position, m_not_found);
            if (s_valid && s_ready) sb.note_item(s_command, s_value);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, sb.pending_answers.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
                rx_left = $urandom_range(16, 200);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
                default:   m_ready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    task automatic send_item(logic [elbs_pkg::CMD_W-1:0] cmd,
                             logic signed [elbs_pkg::VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_command <= cmd;
        s_value   <= val;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic load_ascending(int n, longint start, int unsigned spread);
        longint cur;
        cur = start;
        for (int i = 0; i < n; i++) begin
            send_item(elbs_pkg::CMD_APPEND, cur[elbs_pkg::VAL_W-1:0]);
            cur = cur + longint'($urandom_range(0, spread));
            if (cur > VAL_MAX_L) cur = VAL_MAX_L;
        end
    endtask

    function automatic logic signed [elbs_pkg::VAL_W-1:0] pick_key();
        int                                r;
        int unsigned                       idx;
        logic signed [elbs_pkg::VAL_W-1:0] k;
        r = $urandom_range(0, 9);
        if (sb.entry_count == 0 || r < 2) return $urandom;
        if (r == 2) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        idx = $urandom_range(0, sb.entry_count - 1);
        k   = sb.store_vals[idx];
        case (r % 3)
            0:       k = k - 1;
            1:       k = k + 1;
            default: ;
        endcase
        return k;
    endfunction

    task automatic ask_queries(int n);
        repeat (n) send_item(elbs_pkg::CMD_QUERY, pick_key());
    endtask

    initial begin
        int          r;
        int          n;
        longint      start;
        int unsigned spread;
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_command = elbs_pkg::CMD_CLEAR;
        s_value   = '0;
        m_ready   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners
        send_item(elbs_pkg::CMD_QUERY, 32'sd0);
        send_item(CMD_UNUSED, 32'shffff_ffff);
        send_item(elbs_pkg::CMD_APPEND, VAL_MIN);
        send_item(elbs_pkg::CMD_QUERY, VAL_MIN);
        send_item(elbs_pkg::CMD_QUERY, VAL_MAX);
        send_item(elbs_pkg::CMD_APPEND, -32'sd1);
        send_item(elbs_pkg::CMD_APPEND, 32'sd0);
        send_item(elbs_pkg::CMD_APPEND, 32'sd1);
        send_item(elbs_pkg::CMD_APPEND, VAL_MAX);
        send_item(elbs_pkg::CMD_QUERY, -32'sd1);
        send_item(elbs_pkg::CMD_QUERY, 32'sd0);
        send_item(elbs_pkg::CMD_QUERY, 32'sd2);
        send_item(elbs_pkg::CMD_QUERY, VAL_MAX);
        send_item(elbs_pkg::CMD_QUERY, -32'sd2);
        send_item(elbs_pkg::CMD_CLEAR, 32'sd0);
        send_item(elbs_pkg::CMD_QUERY, 32'sd5);
        send_item(elbs_pkg::CMD_APPEND, 32'sd7);
        send_item(elbs_pkg::CMD_APPEND, 32'sd3);
        send_item(elbs_pkg::CMD_QUERY, 32'sd5);
        send_item(elbs_pkg::CMD_QUERY, 32'sd8);

        // receiver holds off while queries keep coming
        hold_req = 1'b1;
        ask_queries(12);

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                if ($urandom_range(0, 3) != 0) send_item(elbs_pkg::CMD_CLEAR, $urandom);
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(0, 40);
                case ($urandom_range(0, 3))
                    0:       spread = 3;
                    1:       spread = 1000;
                    2:       spread = 1 << 20;
                    default: spread = 1 << 26;
                endcase
                if (sb.entry_count > 0) start = longint'(sb.store_vals[sb.entry_count - 1]);
                else if ($urandom_range(0, 3) == 0) start = VAL_MIN_L;
                else start = longint'($signed($urandom()));
                load_ascending(n, start, spread);
                ask_queries($urandom_range(2, 12));
            end else if (r < 80) begin
                if ($urandom_range(0, 1)) send_item(elbs_pkg::CMD_CLEAR, $urandom);
                repeat ($urandom_range(1, 30)) send_item(elbs_pkg::CMD_APPEND, $urandom);
                ask_queries($urandom_range(2, 10));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0:       send_item(CMD_UNUSED, $urandom);
                        1:       send_item(elbs_pkg::CMD_CLEAR, $urandom);
                        2:       send_item(elbs_pkg::CMD_QUERY, $urandom);
                        default: send_item(elbs_pkg::CMD_APPEND, $urandom);
                    endcase
                end
            end
        end

        // long ascending run, queries at its ends, then more queries while the receiver holds off
        send_item(elbs_pkg::CMD_CLEAR, 32'sd0);
        load_ascending(TAIL_LOAD, VAL_MIN_L, 250000);
        send_item(elbs_pkg::CMD_QUERY, VAL_MAX);
        send_item(elbs_pkg::CMD_QUERY, VAL_MIN);
        send_item(elbs_pkg::CMD_QUERY, sb.store_vals[sb.entry_count - 1]);
        hold_req = 1'b1;
        ask_queries(40);
        send_item(elbs_pkg::CMD_CLEAR, 32'sd0);
        send_item(elbs_pkg::CMD_QUERY, $urandom);
        s_valid <= 1'b0;

        while (sb.pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.pending_answers.size() != 0) begin
            $error("%0d results never arrived", sb.pending_answers.size());
            sb.errors++;
        end

        $display("%0d transfers in, %0d queries checked, %0d of them misses",
                 items_sent, sb.answers_checked, sb.misses);
        $display("store filled to %0d entries, %0d appends dropped on a full store, %0d cycles",
                 sb.peak_count, sb.appends_dropped, cycle_count);
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
